// File: src/ssm_pkg.sv
// ============================================================================
// Sparse set membership package
// Operation and status codes, field widths and controller states shared by
// the sparse set membership table.
// ============================================================================
`default_nettype none

package ssm_pkg;

  // Field widths fixed by the beat format
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 10;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 9;

  // Operation codes; the unused code acts as a lookup
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OpW-1:0] OP_DELETE = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] STS_DONE    = 2'd0;
  localparam logic [StatusW-1:0] STS_FULL    = 2'd1;
  localparam logic [StatusW-1:0] STS_PRESENT = 2'd2;
  localparam logic [StatusW-1:0] STS_ABSENT  = 2'd3;

  // Capacity limit register value after reset
  localparam logic [CountW-1:0] CapLimitRst = 9'd256;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,   // sweep the key-to-slot memory to zero
    ST_IDLE,    // wait for a beat, read key-to-slot entry
    ST_SPARSE,  // slot known, read slot-to-key entry
    ST_CHECK,   // membership known, decide and update
    ST_LAST     // last dense entry known, move it into the freed slot
  } state_e;

endpackage : ssm_pkg

`default_nettype wire

// File: src/sparse_set_membership.sv
// ============================================================================
// Sparse set membership table
// Keeps a key-to-slot memory, a slot-to-key memory and a member count, and
// answers insert, lookup and delete beats with presence, status and count.
// ============================================================================
// Sequence: an accepted beat reads the key-to-slot memory in ST_IDLE and the
//   slot-to-key memory in ST_SPARSE; its result is registered from ST_CHECK,
//   or from ST_LAST for a delete of a present key, once the output can load.
// Overlap: none; a new beat is taken only back in ST_IDLE, after the previous
//   result is loaded, as the sequence reads then writes two single-port memories.
// Reset: count clears and the key-to-slot memory is swept to zero, one entry
//   a cycle, with the input stalled; config writes are taken throughout.
`default_nettype none

module sparse_set_membership #(
  parameter int unsigned KEY_RANGE = 1024,
  parameter int unsigned CAPACITY  = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [ssm_pkg::CountW-1:0]    cfg_wdata_i,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ssm_pkg::OpW-1:0]       operation_i,
  input  wire logic [ssm_pkg::KeyW-1:0]      key_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               was_present_o,
  output logic [ssm_pkg::StatusW-1:0]        status_o,
  output logic [ssm_pkg::CountW-1:0]         member_count_o
);

  // Derived widths
  localparam int unsigned KeyIdxW = (KEY_RANGE > 2) ? $clog2(KEY_RANGE) : 1;
  localparam int unsigned KeyExtW = (KeyIdxW > ssm_pkg::KeyW) ? KeyIdxW : ssm_pkg::KeyW;
  localparam int unsigned SlotW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW    = (CntW > ssm_pkg::CountW) ? CntW : ssm_pkg::CountW;

  localparam logic [KeyExtW:0]   KeyRangeC = (KeyExtW+1)'(KEY_RANGE);
  localparam logic [KeyIdxW-1:0] ClrLastC  = KeyIdxW'(KEY_RANGE - 1);
  localparam logic [CntW-1:0]    CapC      = CntW'(CAPACITY);

  // Memories
  logic [SlotW-1:0]   sparse_mem [KEY_RANGE];
  logic [KeyIdxW-1:0] dense_mem  [CAPACITY];

  // Registers
  ssm_pkg::state_e               state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [KeyIdxW-1:0]            clr_q;
  logic [ssm_pkg::CountW-1:0]    cap_limit_q;
  logic [ssm_pkg::OpW-1:0]       op_q;
  logic [ssm_pkg::KeyW-1:0]      key_q;
  logic [SlotW-1:0]              sp_rdata_q;
  logic [KeyIdxW-1:0]            dn_rdata_q;
  logic                          out_valid_q, out_valid_d;
  logic                          res_present_q;
  logic [ssm_pkg::StatusW-1:0]   res_status_q;
  logic [ssm_pkg::CountW-1:0]    res_count_q;

  // Memory controls and result load
  logic                          sp_we, sp_re;
  logic [KeyIdxW-1:0]            sp_addr;
  logic [SlotW-1:0]              sp_wdata;
  logic                          dn_we, dn_re;
  logic [SlotW-1:0]              dn_addr;
  logic [KeyIdxW-1:0]            dn_wdata;
  logic                          res_load;
  logic                          res_present;
  logic [ssm_pkg::StatusW-1:0]   res_status;

  // Decoded terms
  logic [KeyExtW-1:0]            in_key_ext, key_ext;
  logic [KeyIdxW-1:0]            in_key_idx, key_idx;
  logic                          in_range;
  logic                          present;
  logic                          full;
  logic                          can_load;
  logic                          del_hit;
  logic                          clr_done;
  logic [CmpW-1:0]               count_ext, count_d_ext;
  logic [SlotW-1:0]              count_slot, last_slot;
  logic [CntW-1:0]               count_dec;

  // Key index and range
  assign in_key_ext = KeyExtW'(key_i);
  assign in_key_idx = in_key_ext[KeyIdxW-1:0];
  assign key_ext    = KeyExtW'(key_q);
  assign key_idx    = key_ext[KeyIdxW-1:0];
  assign in_range   = {1'b0, key_ext} < KeyRangeC;

  // Membership: slot below count and the dense entry points back
  assign present = in_range && (CntW'(sp_rdata_q) < count_q) && (dn_rdata_q == key_idx);

  // Full when count reaches the register limit or the memory size
  assign count_ext = CmpW'(count_q);
  assign full      = (count_ext >= CmpW'(cap_limit_q)) || (count_q >= CapC);

  assign count_dec  = count_q - 1'b1;
  assign count_slot = count_q[SlotW-1:0];
  assign last_slot  = count_dec[SlotW-1:0];

  assign can_load = !out_valid_q || !out_stall_i;
  assign del_hit  = (op_q == ssm_pkg::OP_DELETE) && present;
  assign clr_done = (clr_q == ClrLastC);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssm_pkg::ST_CLEAR:  if (clr_done) state_d = ssm_pkg::ST_IDLE;
      ssm_pkg::ST_IDLE:   if (in_valid_i) state_d = ssm_pkg::ST_SPARSE;
      ssm_pkg::ST_SPARSE: state_d = ssm_pkg::ST_CHECK;
      ssm_pkg::ST_CHECK: begin
        if (del_hit) begin
          state_d = ssm_pkg::ST_LAST;
        end else if (can_load) begin
          state_d = ssm_pkg::ST_IDLE;
        end
      end
      ssm_pkg::ST_LAST:   if (can_load) state_d = ssm_pkg::ST_IDLE;
      default:            state_d = ssm_pkg::ST_CLEAR;
    endcase
  end

  // Memory accesses, count update and result per state
  always_comb begin
    in_stall_o  = 1'b1;
    sp_we       = 1'b0;
    sp_re       = 1'b0;
    sp_addr     = key_idx;
    sp_wdata    = '0;
    dn_we       = 1'b0;
    dn_re       = 1'b0;
    dn_addr     = sp_rdata_q;
    dn_wdata    = key_idx;
    count_d     = count_q;
    res_load    = 1'b0;
    res_present = present;
    res_status  = ssm_pkg::STS_DONE;
    case (state_q)
      ssm_pkg::ST_CLEAR: begin
        sp_we   = 1'b1;
        sp_addr = clr_q;
      end
      ssm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        sp_re      = in_valid_i;
        sp_addr    = in_key_idx;
      end
      ssm_pkg::ST_SPARSE: begin
        dn_re = 1'b1;
      end
      ssm_pkg::ST_CHECK: begin
        case (op_q)
          ssm_pkg::OP_INSERT: begin
            res_load = can_load;
            if (present) begin
              res_status = ssm_pkg::STS_PRESENT;
            end else if (!in_range || full) begin
              res_status = ssm_pkg::STS_FULL;
            end else if (can_load) begin
              // append at slot count
              dn_we    = 1'b1;
              dn_addr  = count_slot;
              sp_we    = 1'b1;
              sp_wdata = count_slot;
              count_d  = count_q + 1'b1;
            end
          end
          ssm_pkg::OP_DELETE: begin
            if (present) begin
              // fetch the last dense entry
              dn_re   = 1'b1;
              dn_addr = last_slot;
            end else begin
              res_load   = can_load;
              res_status = ssm_pkg::STS_ABSENT;
            end
          end
          default: begin
            res_load = can_load;
          end
        endcase
      end
      ssm_pkg::ST_LAST: begin
        res_present = 1'b1;
        if (can_load) begin
          // move last key into the freed slot
          res_load = 1'b1;
          dn_we    = 1'b1;
          dn_addr  = sp_rdata_q;
          dn_wdata = dn_rdata_q;
          sp_we    = 1'b1;
          sp_addr  = dn_rdata_q;
          sp_wdata = sp_rdata_q;
          count_d  = count_dec;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign count_d_ext = CmpW'(count_d);
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  // Key-to-slot memory
  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      sparse_mem[sp_addr] <= sp_wdata;
    end
    if (sp_re) begin
      sp_rdata_q <= sparse_mem[sp_addr];
    end
  end

  // Slot-to-key memory
  always_ff @(posedge clk_i) begin
    if (dn_we) begin
      dense_mem[dn_addr] <= dn_wdata;
    end
    if (dn_re) begin
      dn_rdata_q <= dense_mem[dn_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssm_pkg::ST_CLEAR;
      count_q     <= '0;
      clr_q       <= '0;
      cap_limit_q <= ssm_pkg::CapLimitRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (state_q == ssm_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        cap_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Beat and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ssm_pkg::ST_IDLE && in_valid_i) begin
      op_q  <= operation_i;
      key_q <= key_i;
    end
    if (res_load) begin
      res_present_q <= res_present;
      res_status_q  <= res_status;
      res_count_q   <= count_d_ext[ssm_pkg::CountW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_present_o  = res_present_q;
  assign status_o       = res_status_q;
  assign member_count_o = res_count_q;

`ifndef SYNTHESIS
  // count never goes past the memory size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("member count above capacity");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
    else $error("member count jumped");

  // an accepted beat starts the lookup sequence
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ssm_pkg::ST_SPARSE)
    else $error("accepted beat did not start a lookup");

  // a new result only comes out of a deciding state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      ($past(state_q) == ssm_pkg::ST_CHECK || $past(state_q) == ssm_pkg::ST_LAST))
    else $error("result produced outside a deciding state");
`endif

endmodule : sparse_set_membership

`default_nettype wire

// File: sim/sparse_set_membership_tb.sv
// ============================================================================
// Sparse set membership testbench
// Drives insert, lookup and delete beats into the table under random valid
// and stall gaps, and checks every result beat against a behavioral copy of
// the table (key-to-slot, slot-to-key, member count and capacity limit).
// ============================================================================
`default_nettype none

// One expected result beat
typedef struct packed {
  logic                              was_present;
  logic [ssm_pkg::StatusW-1:0]       status;
  logic [ssm_pkg::CountW-1:0]        member_count;
} ssm_result_t;

// Behavioral table plus the queue of results it still owes
class membership_scoreboard;
  localparam int unsigned NumKeys  = 1024;
  localparam int unsigned NumSlots = 256;

  bit [7:0]                  slot_of_key [NumKeys];
  bit [ssm_pkg::KeyW-1:0]    key_of_slot [NumSlots];
  bit [ssm_pkg::CountW-1:0]  members;
  bit [ssm_pkg::CountW-1:0]  cap_limit;
  ssm_result_t               expected_q [$];

  int unsigned mismatches;
  int unsigned inserts, lookups, deletes;
  int unsigned full_hits, present_hits, absent_hits;
  int unsigned peak;

  function new();
    foreach (slot_of_key[i]) slot_of_key[i] = '0;
    foreach (key_of_slot[i]) key_of_slot[i] = '0;
    members   = '0;
    cap_limit = ssm_pkg::CapLimitRst;
  endfunction

  // A key is a member when its slot is live and the slot points back
  function bit holds_key(bit [ssm_pkg::KeyW-1:0] k);
    bit [7:0] s;
    s = slot_of_key[k];
    if ({1'b0, s} >= members) return 1'b0;
    return key_of_slot[s] == k;
  endfunction

  // Accepted input beat: update the table, queue the result it owes
  function void note_beat(logic [ssm_pkg::OpW-1:0] op, logic [ssm_pkg::KeyW-1:0] k);
    ssm_result_t               r;
    bit [ssm_pkg::CountW-1:0]  lim;
    bit [7:0]                  freed;
    bit [ssm_pkg::KeyW-1:0]    last;
    lim = (cap_limit < 9'd256) ? cap_limit : 9'd256;
    r.was_present = holds_key(k);
    r.status      = ssm_pkg::STS_DONE;
    case (op)
      ssm_pkg::OP_INSERT: begin
        inserts++;
        if (r.was_present) begin
          r.status = ssm_pkg::STS_PRESENT;
        end else if (members >= lim) begin
          r.status = ssm_pkg::STS_FULL;
        end else begin
          key_of_slot[members[7:0]] = k;
          slot_of_key[k]            = members[7:0];
          members++;
        end
      end
      ssm_pkg::OP_DELETE: begin
        deletes++;
        if (!r.was_present) begin
          r.status = ssm_pkg::STS_ABSENT;
        end else begin
          // last dense entry fills the freed slot
          freed               = slot_of_key[k];
          last                = key_of_slot[members[7:0] - 8'd1];
          key_of_slot[freed]  = last;
          slot_of_key[last]   = freed;
          members--;
        end
      end
      default: lookups++;   // lookup and the unused code
    endcase
    r.member_count = members;
    case (r.status)
      ssm_pkg::STS_FULL:    full_hits++;
      ssm_pkg::STS_PRESENT: present_hits++;
      ssm_pkg::STS_ABSENT:  absent_hits++;
      default: ;
    endcase
    if (members > peak) peak = members;
    expected_q.push_back(r);
  endfunction

  // Accepted result beat: compare with the oldest expectation
  function void check_result(logic wp, logic [ssm_pkg::StatusW-1:0] st,
                             logic [ssm_pkg::CountW-1:0] cnt);
    ssm_result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: present=%0d status=%0d count=%0d", wp, st, cnt);
      return;
    end
    e = expected_q.pop_front();
    if (e.was_present !== wp || e.status !== st || e.member_count !== cnt) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: exp present=%0d status=%0d count=%0d, got %0d %0d %0d",
                 e.was_present, e.status, e.member_count, wp, st, cnt);
    end
  endfunction
endclass

module sparse_set_membership_tb;

  localparam logic [ssm_pkg::OpW-1:0] OP_UNUSED     = 2'd3;
  localparam int unsigned             WatchdogLimit = 4000;
  localparam int unsigned             HistDepth     = 320;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ssm_pkg::CountW-1:0]    cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [ssm_pkg::OpW-1:0]       operation_i;
  logic [ssm_pkg::KeyW-1:0]      key_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          was_present_o;
  logic [ssm_pkg::StatusW-1:0]   status_o;
  logic [ssm_pkg::CountW-1:0]    member_count_o;

  membership_scoreboard          sb;
  logic [ssm_pkg::KeyW-1:0]      inserted_keys [$];
  int unsigned                   beats_sent;
  int unsigned                   idle_cycles;
  bit                            tx_quiet;
  bit                            rx_quiet;
  int unsigned                   results_taken;

  sparse_set_membership #(
    .KEY_RANGE (1024),
    .CAPACITY  (256)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .was_present_o  (was_present_o),
    .status_o       (status_o),
    .member_count_o (member_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Send one beat after a random gap; valid stays high across back-to-back beats
  task automatic send_beat(logic [ssm_pkg::OpW-1:0] op, logic [ssm_pkg::KeyW-1:0] k);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_beat(op, k);
    beats_sent++;
    if (beats_sent % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Drain all results, then write the capacity limit while the table is idle
  task automatic write_cap_limit(logic [ssm_pkg::CountW-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.cap_limit = v;
  endtask

  // Random beats; keys mostly reused from earlier inserts when reuse is high
  task automatic random_phase(int unsigned n, int unsigned ins_pct, int unsigned del_pct,
                              int unsigned reuse_pct);
    int unsigned              r;
    logic [ssm_pkg::OpW-1:0]  op;
    logic [ssm_pkg::KeyW-1:0] k;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct)                op = ssm_pkg::OP_INSERT;
      else if (r < ins_pct + del_pct) op = ssm_pkg::OP_DELETE;
      else op = ($urandom_range(0, 7) == 0) ? OP_UNUSED : ssm_pkg::OP_LOOKUP;
      if (inserted_keys.size() != 0 && $urandom_range(0, 99) < reuse_pct)
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      else
        k = ssm_pkg::KeyW'($urandom_range(0, 1023));
      if (op == ssm_pkg::OP_INSERT) begin
        inserted_keys.push_back(k);
        if (inserted_keys.size() > HistDepth) void'(inserted_keys.pop_front());
      end
      send_beat(op, k);
    end
  endtask

  // Result side: random stall before each beat, with stall-free stretches
  initial begin
    int unsigned wait_n;
    forever begin
      wait_n = rx_quiet ? 0 : $urandom_range(0, 9);
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(was_present_o, status_o, member_count_o);
      results_taken++;
      if (results_taken % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    sb          = new();
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    operation_i <= ssm_pkg::OP_LOOKUP;
    key_i       <= '0;
    rst_ni      <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, repeats, stale entries, self-move delete
    write_cap_limit(ssm_pkg::CapLimitRst);
    send_beat(ssm_pkg::OP_INSERT, 10'd0);
    send_beat(ssm_pkg::OP_INSERT, 10'd1023);
    send_beat(ssm_pkg::OP_INSERT, 10'd0);      // already present
    send_beat(ssm_pkg::OP_LOOKUP, 10'd0);
    send_beat(ssm_pkg::OP_LOOKUP, 10'd1023);
    send_beat(ssm_pkg::OP_LOOKUP, 10'd512);    // never written, sparse entry still zero
    send_beat(OP_UNUSED, 10'd1023);            // acts as lookup
    send_beat(ssm_pkg::OP_DELETE, 10'd7);      // absent
    send_beat(ssm_pkg::OP_INSERT, 10'h155);
    send_beat(ssm_pkg::OP_INSERT, 10'h2aa);
    send_beat(ssm_pkg::OP_DELETE, 10'd0);      // last entry moves into slot 0
    send_beat(ssm_pkg::OP_LOOKUP, 10'h2aa);
    send_beat(ssm_pkg::OP_LOOKUP, 10'd0);      // stale sparse entry
    send_beat(ssm_pkg::OP_DELETE, 10'h2aa);
    send_beat(ssm_pkg::OP_DELETE, 10'd1023);   // deletes the last entry itself
    send_beat(ssm_pkg::OP_INSERT, 10'd0);

    // Small limit: full table, present check ahead of capacity check
    write_cap_limit(9'd2);
    send_beat(ssm_pkg::OP_INSERT, 10'd5);
    send_beat(ssm_pkg::OP_INSERT, 10'd0);
    send_beat(ssm_pkg::OP_DELETE, 10'h155);
    send_beat(ssm_pkg::OP_INSERT, 10'd5);
    write_cap_limit(9'd0);
    send_beat(ssm_pkg::OP_INSERT, 10'd9);
    send_beat(ssm_pkg::OP_LOOKUP, 10'd5);

    // Random: fill past capacity, drain, then churn under small limits
    write_cap_limit(9'd511);
    random_phase(300, 90, 3, 5);
    write_cap_limit(9'd255);
    random_phase(150, 20, 60, 85);
    write_cap_limit(9'd1);
    random_phase(20, 50, 25, 60);
    write_cap_limit(9'd3);
    random_phase(60, 35, 35, 70);
    write_cap_limit(ssm_pkg::CountW'($urandom_range(4, 250)));
    random_phase(30, 40, 30, 60);

    // Wind down
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.mismatches += sb.expected_q.size();

    $display("Sent %0d beats: %0d inserts, %0d lookups, %0d deletes; peak of %0d members",
             beats_sent, sb.inserts, sb.lookups, sb.deletes, sb.peak);
    $display("Rejects seen: %0d table full, %0d already present, %0d absent on delete",
             sb.full_hits, sb.present_hits, sb.absent_hits);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
